// ----- rtl/multi_stream_swb_lcg_rng_defines.svh -----
// Assertion macros shared by the RTL
`ifndef MULTI_STREAM_SWB_LCG_RNG_DEFINES_SVH
`define MULTI_STREAM_SWB_LCG_RNG_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge
`define MSRNG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, sampled on the rising clock edge
`define MSRNG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MSRNG_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MSRNG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/msrng_pkg.sv -----
package msrng_pkg;

   // Default number of streams in the table
   localparam int NUM_STREAMS_DEF = 8;

   localparam logic [31:0] LCG_MUL    = 32'd69069;
   localparam logic [31:0] LCG_ADD    = 32'd1013904243;
   localparam logic [31:0] SWB_OFFSET = 32'd18;

   // Operation codes
   typedef enum logic [2:0] {
      FUNC_DRAW  = 3'd0,
      FUNC_LOAD  = 3'd1,
      FUNC_SET_N = 3'd2,
      FUNC_READ  = 3'd3,
      FUNC_RESET = 3'd4
   } func_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_REPLY
   } ctl_state_type;

   // One stream's full state, as held in one memory entry
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        c;
      logic [31:0] n;
   } stream_state_type;

   localparam stream_state_type DEF_STATE = '{
      x: 32'd521288629,
      y: 32'd362436069,
      z: 32'd1613801,
      c: 1'b1,
      n: 32'd1131199209
   };

endpackage

// ----- rtl/multi_stream_swb_lcg_rng.sv -----
// Multi-stream subtract-with-borrow plus congruential random number source.
// Command channel: drive req_* with start high; the transaction is taken at a
// rising edge where start is high and busy is low. func selects draw, load of
// all parameters, set of n, read back, or restore of one stream to defaults.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_* valid;
// the receiver cannot hold it off and must take it in that cycle.
// Timing: the state memory is read at the accepting edge; the update and
// write-back happen in the APPLY state, which registers the result, and
// rsp_strobe is then high in the REPLY state.
// Busy: busy is high in the APPLY (update) state, set by the read-modify-write
// round trip through the memory, so no transaction is taken during an update.
// A new transaction may be taken while the previous result is on rsp_*.
// Reset (synchronous, active high) clears the per-stream valid bits at once;
// a stream never written since reset reads as the default state, so no
// clearing pass is needed and the block is ready the cycle after reset.
// A stream index at or beyond NUM_STREAMS changes nothing and returns zeros.
`include "multi_stream_swb_lcg_rng_defines.svh"

module multi_stream_swb_lcg_rng #(
   parameter int NUM_STREAMS = msrng_pkg::NUM_STREAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_stream_sel,
   input  logic [31:0] req_x_value,
   input  logic [31:0] req_y_value,
   input  logic [31:0] req_z_value,
   input  logic        req_carry_value,
   input  logic [31:0] req_n_value,
   output logic        rsp_strobe,
   output logic [31:0] rsp_random_word,
   output logic [31:0] rsp_x_out,
   output logic [31:0] rsp_y_out,
   output logic [31:0] rsp_z_out,
   output logic        rsp_carry_out,
   output logic [31:0] rsp_n_out
);
   import msrng_pkg::*;

   localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   // Stream state memory and per-entry valid bits
   stream_state_type       mem [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] valid_ff;

   ctl_state_type    state_ff, state_in;
   logic             accept;
   logic             req_in_range;
   logic [IDX_W-1:0] req_idx;

   // Captured transaction
   logic [2:0]       func_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             in_range_ff;
   stream_state_type load_ff;

   // Memory read data and its valid flag
   stream_state_type rd_data_ff;
   logic             rd_valid_ff;

   // Update stage
   stream_state_type cur;
   stream_state_type upd_in;
   logic             wr_en;
   logic [31:0]      swb_t;
   logic [31:0]      lcg_prod;

   // Result registers
   stream_state_type res_ff, res_in;
   logic             draw_ff, draw_in;

   assign accept       = start && !busy;
   assign req_in_range = (32'(req_stream_sel) < NUM_STREAMS);
   assign req_idx      = IDX_W'(req_stream_sel);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_REPLY;
         ST_REPLY: state_in = accept ? ST_APPLY : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      busy       = 1'b0;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE:  ;
         ST_APPLY: busy = 1'b1;
         ST_REPLY: rsp_strobe = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the transaction and issue the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= req_func;
         idx_ff      <= req_idx;
         in_range_ff <= req_in_range;
         load_ff     <= '{x: req_x_value, y: req_y_value, z: req_z_value,
                          c: req_carry_value, n: req_n_value};
         if (req_in_range) begin
            rd_data_ff  <= mem[req_idx];
            rd_valid_ff <= valid_ff[req_idx];
         end else begin
            rd_data_ff  <= DEF_STATE;
            rd_valid_ff <= 1'b0;
         end
      end
   end

   // Untouched streams read as defaults
   assign cur      = rd_valid_ff ? rd_data_ff : DEF_STATE;
   assign swb_t    = cur.x + 32'(cur.c);
   assign lcg_prod = cur.n * LCG_MUL;

   // Apply the operation to the stream
   always_comb begin
      upd_in  = cur;
      wr_en   = 1'b0;
      draw_in = 1'b0;
      unique case (func_ff)
         FUNC_DRAW: begin
            upd_in.x = cur.y;
            upd_in.y = cur.z;
            if (cur.y > swb_t) begin
               upd_in.z = cur.y - swb_t;
               upd_in.c = 1'b0;
            end else begin
               upd_in.z = swb_t - cur.y - SWB_OFFSET;
               upd_in.c = 1'b1;
            end
            upd_in.n = lcg_prod + LCG_ADD;
            wr_en    = 1'b1;
            draw_in  = 1'b1;
         end
         FUNC_LOAD: begin
            upd_in = load_ff;
            wr_en  = 1'b1;
         end
         FUNC_SET_N: begin
            upd_in.n = load_ff.n;
            wr_en    = 1'b1;
         end
         FUNC_RESET: begin
            upd_in = DEF_STATE;
            wr_en  = 1'b1;
         end
         default: ;
      endcase
      if (!in_range_ff) begin
         wr_en   = 1'b0;
         draw_in = 1'b0;
      end
      res_in = in_range_ff ? upd_in : '0;
   end

   // Write back and hold the result
   always_ff @(posedge clock) begin
      if (state_ff == ST_APPLY) begin
         res_ff  <= res_in;
         draw_ff <= draw_in;
         if (wr_en) mem[idx_ff] <= upd_in;
      end
   end

   // Mark streams written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (state_ff == ST_APPLY && wr_en) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Drive the result ports
   assign rsp_random_word = draw_ff ? (res_ff.z + res_ff.n) : 32'd0;
   assign rsp_x_out       = res_ff.x;
   assign rsp_y_out       = res_ff.y;
   assign rsp_z_out       = res_ff.z;
   assign rsp_carry_out   = res_ff.c;
   assign rsp_n_out       = res_ff.n;

   // Checks
   `MSRNG_ASSERT_NEXT(a_accept_to_apply, clock, reset, accept, state_ff == ST_APPLY)
   `MSRNG_ASSERT_NEXT(a_apply_to_reply, clock, reset, busy, rsp_strobe)
   `MSRNG_ASSERT_IMPL(a_reply_after_apply, clock, reset, rsp_strobe, $past(busy))
   `MSRNG_ASSERT_IMPL(a_range_zero, clock, reset, rsp_strobe && !in_range_ff, res_ff == '0)

endmodule
